FILE: rtl/box_axis_overlap_depth_core_macros.svh
`ifndef BOX_AXIS_OVERLAP_DEPTH_CORE_MACROS_SVH
`define BOX_AXIS_OVERLAP_DEPTH_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BAO_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bao assertion failed");

// Next-cycle implication, checked outside reset.
`define BAO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bao assertion failed");

`endif

FILE: rtl/bao_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bao_pkg;

    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int DEPTH_BITS          = 18;

endpackage

`default_nettype wire

FILE: rtl/bao_proj.sv
`timescale 1ns / 1ps
`default_nettype none

module bao_proj
    import bao_pkg::*;
#(
    parameter int W = COMPONENT_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [3*W-1:0]   i_first_low_corner,
    input  wire logic [3*W-1:0]   i_first_high_corner,
    input  wire logic [3*W-1:0]   i_second_low_corner,
    input  wire logic [3*W-1:0]   i_second_high_corner,
    input  wire logic [3*W-1:0]   i_test_axis,
    output logic                  o_valid,
    output logic [2*W+3:0]        o_mag,
    output logic                  o_neg,
    output logic [2*W-1:0]        o_q,
    output logic                  o_degen
);

    localparam int DCW = W + 2;
    localparam int EW  = W + 1;
    localparam int CPW = 2 * W + 2;
    localparam int EPW = 2 * W + 1;
    localparam int AW  = 2 * W;
    localparam int XW  = 2 * W + 4;
    localparam int RDW = 2 * W + 3;
    localparam int SW  = 2 * W + 5;

    logic signed [W-1:0]   c_l1 [3];
    logic signed [W-1:0]   c_h1 [3];
    logic signed [W-1:0]   c_l2 [3];
    logic signed [W-1:0]   c_h2 [3];
    logic signed [W-1:0]   c_a  [3];
    logic signed [DCW-1:0] c_dc [3];
    logic signed [EW-1:0]  c_e1 [3];
    logic signed [EW-1:0]  c_e2 [3];
    logic signed [CPW-1:0] n_cp [3];
    logic signed [EPW-1:0] c_p1 [3];
    logic signed [EPW-1:0] c_p2 [3];
    logic [AW-1:0]         n_ep [6];
    logic signed [AW-1:0]  c_sq [3];
    logic [AW-1:0]         n_aa [3];

    logic signed [CPW-1:0] r_cp [3];
    logic [AW-1:0]         r_ep [6];
    logic [AW-1:0]         r_aa [3];
    logic                  r_v1;
    logic                  r_dg1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_l1[i] = $signed(i_first_low_corner[i*W +: W]);
            c_h1[i] = $signed(i_first_high_corner[i*W +: W]);
            c_l2[i] = $signed(i_second_low_corner[i*W +: W]);
            c_h2[i] = $signed(i_second_high_corner[i*W +: W]);
            c_a[i]  = $signed(i_test_axis[i*W +: W]);
            c_dc[i] = DCW'(c_l1[i]) + DCW'(c_h1[i]) - DCW'(c_l2[i]) - DCW'(c_h2[i]);
            c_e1[i] = EW'(c_h1[i]) - EW'(c_l1[i]);
            c_e2[i] = EW'(c_h2[i]) - EW'(c_l2[i]);
            n_cp[i] = CPW'(c_dc[i]) * CPW'(c_a[i]);
            c_p1[i] = EPW'(c_e1[i]) * EPW'(c_a[i]);
            c_p2[i] = EPW'(c_e2[i]) * EPW'(c_a[i]);
            n_ep[2*i]   = c_p1[i][EPW-1] ? AW'(-c_p1[i]) : AW'(c_p1[i]);
            n_ep[2*i+1] = c_p2[i][EPW-1] ? AW'(-c_p2[i]) : AW'(c_p2[i]);
            c_sq[i] = AW'(c_a[i]) * AW'(c_a[i]);
            n_aa[i] = c_sq[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_cp  <= n_cp;
            r_ep  <= n_ep;
            r_aa  <= n_aa;
            r_dg1 <= (i_test_axis == '0);
        end
    end

    logic signed [XW-1:0] n_cross;
    logic [RDW-1:0]       n_radius;
    logic [AW-1:0]        n_q;
    logic signed [XW-1:0] r_cross;
    logic [RDW-1:0]       r_radius;
    logic [AW-1:0]        r_q2;
    logic                 r_v2;
    logic                 r_dg2;

    always_comb begin
        n_cross  = XW'(r_cp[0]) + XW'(r_cp[1]) + XW'(r_cp[2]);
        n_radius = RDW'(r_ep[0]) + RDW'(r_ep[1]) + RDW'(r_ep[2])
                 + RDW'(r_ep[3]) + RDW'(r_ep[4]) + RDW'(r_ep[5]);
        n_q      = r_aa[0] + r_aa[1] + r_aa[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_cross  <= n_cross;
            r_radius <= n_radius;
            r_q2     <= n_q;
            r_dg2    <= r_dg1;
        end
    end

    logic [XW-1:0]        c_acr;
    logic signed [SW-1:0] c_s;
    logic [SW-1:0]        c_smag;
    logic [XW-1:0]        r_mag;
    logic                 r_neg;
    logic [AW-1:0]        r_q3;
    logic                 r_v3;
    logic                 r_dg3;

    always_comb begin
        c_acr  = r_cross[XW-1] ? XW'(-r_cross) : XW'(r_cross);
        c_s    = $signed({1'b0, c_acr}) - $signed({2'b00, r_radius});
        c_smag = c_s[SW-1] ? SW'(-c_s) : SW'(c_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= r_v2;
        end
        if (i_en) begin
            r_mag <= c_smag[XW-1:0];
            r_neg <= c_s[SW-1];
            r_q3  <= r_q2;
            r_dg3 <= r_dg2;
        end
    end

    assign o_valid = r_v3;
    assign o_mag   = r_mag;
    assign o_neg   = r_neg;
    assign o_q     = r_q3;
    assign o_degen = r_dg3;

endmodule

`default_nettype wire

FILE: rtl/bao_square.sv
`timescale 1ns / 1ps
`default_nettype none

module bao_square
    import bao_pkg::*;
#(
    parameter int W = COMPONENT_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [2*W+3:0]     i_mag,
    input  wire logic               i_neg,
    input  wire logic [2*W-1:0]     i_q,
    input  wire logic               i_degen,
    output logic                    o_valid,
    output logic [4*W+7:0]          o_sq,
    output logic                    o_neg,
    output logic [2*W-1:0]          o_q,
    output logic                    o_degen
);

    localparam int MW = 2 * W + 4;
    localparam int LW = MW / 2;
    localparam int HW = MW - LW;
    localparam int QW = 2 * MW;

    logic [HW-1:0]    c_hi;
    logic [LW-1:0]    c_lo;
    logic [2*HW-1:0]  r_hh;
    logic [HW+LW-1:0] r_hl;
    logic [2*LW-1:0]  r_ll;
    logic             r_v1;
    logic             r_neg1;
    logic [2*W-1:0]   r_q1;
    logic             r_dg1;

    assign c_hi = i_mag[MW-1:LW];
    assign c_lo = i_mag[LW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
        if (i_en) begin
            r_hh   <= (2*HW)'(c_hi) * (2*HW)'(c_hi);
            r_hl   <= (HW+LW)'(c_hi) * (HW+LW)'(c_lo);
            r_ll   <= (2*LW)'(c_lo) * (2*LW)'(c_lo);
            r_neg1 <= i_neg;
            r_q1   <= i_q;
            r_dg1  <= i_degen;
        end
    end

    logic [QW-1:0]  n_sq;
    logic [QW-1:0]  r_sq;
    logic           r_v2;
    logic           r_neg2;
    logic [2*W-1:0] r_q2;
    logic           r_dg2;

    assign n_sq = (QW'(r_hh) << (2 * LW)) + (QW'(r_hl) << (LW + 1)) + QW'(r_ll);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_sq   <= n_sq;
            r_neg2 <= r_neg1;
            r_q2   <= r_q1;
            r_dg2  <= r_dg1;
        end
    end

    assign o_valid = r_v2;
    assign o_sq    = r_sq;
    assign o_neg   = r_neg2;
    assign o_q     = r_q2;
    assign o_degen = r_dg2;

endmodule

`default_nettype wire

FILE: rtl/bao_root.sv
`timescale 1ns / 1ps
`default_nettype none

module bao_root
    import bao_pkg::*;
#(
    parameter int W = COMPONENT_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire logic [4*W+7:0]        i_sq,
    input  wire logic                  i_neg,
    input  wire logic [2*W-1:0]        i_q,
    input  wire logic                  i_degen,
    output logic                       o_valid,
    output logic [DEPTH_BITS-1:0]      o_depth,
    output logic                       o_neg,
    output logic                       o_degen
);

    localparam int DB = DEPTH_BITS;
    localparam int SQW = 4 * W + 8;
    localparam int DW = 2 * W + 2 * DB + 3;
    localparam int CW = ((SQW > DW) ? SQW : DW) + 1;
    localparam int PW = 2 * W + DB;
    localparam int QW = 2 * W;

    // Each stage settles one result bit; all but the last keep the square's
    // remainder and running product of the partial result with axis norm.
    logic [CW-1:0] r_rem [DB-1];
    logic [PW-1:0] r_p   [DB-1];
    logic [QW-1:0] r_q   [DB-1];
    logic [DB-1:0] r_n   [DB];
    logic          r_v   [DB];
    logic          r_neg [DB];
    logic          r_dg  [DB];

    for (genvar k = 0; k < DB; k++) begin : g_stage
        localparam int B = DB - 1 - k;
        logic [CW-1:0] rem_in;
        logic [PW-1:0] p_in;
        logic [QW-1:0] q_in;
        logic [DB-1:0] n_in;
        logic          v_in;
        logic          neg_in;
        logic          dg_in;
        logic [CW-1:0] d;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_in = CW'(i_sq);
            assign p_in   = '0;
            assign q_in   = i_q;
            assign n_in   = '0;
            assign v_in   = i_valid;
            assign neg_in = i_neg;
            assign dg_in  = i_degen;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign p_in   = r_p[k-1];
            assign q_in   = r_q[k-1];
            assign n_in   = r_n[k-1];
            assign v_in   = r_v[k-1];
            assign neg_in = r_neg[k-1];
            assign dg_in  = r_dg[k-1];
        end

        assign d    = (CW'(p_in) << (B + 3)) + (CW'(q_in) << (2 * B + 2));
        assign take = (rem_in >= d);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
            if (i_en) begin
                r_n[k]   <= take ? (n_in | (DB'(1) << B)) : n_in;
                r_neg[k] <= neg_in;
                r_dg[k]  <= dg_in;
            end
        end

        if (k < DB - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= take ? (rem_in - d) : rem_in;
                    r_p[k]   <= take ? (p_in + (PW'(q_in) << B)) : p_in;
                    r_q[k]   <= q_in;
                end
            end
        end
    end

    assign o_valid = r_v[DB-1];
    assign o_depth = r_n[DB-1];
    assign o_neg   = r_neg[DB-1];
    assign o_degen = r_dg[DB-1];

endmodule

`default_nettype wire

FILE: rtl/box_axis_overlap_depth_core.sv
// Throughput: one request per cycle while the output is not stalled; the
// projection takes three stages, the squaring two, and the square-root
// search one stage per depth bit.
// A stall at the output freezes the whole pipeline until the result is taken.
// Reset is synchronous and active low; it clears only the stage valid bits.
`timescale 1ns / 1ps
`default_nettype none

module box_axis_overlap_depth_core
    import bao_pkg::*;
#(
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [3*COMPONENT_WIDTH-1:0] i_first_low_corner,
    input  wire logic [3*COMPONENT_WIDTH-1:0] i_first_high_corner,
    input  wire logic [3*COMPONENT_WIDTH-1:0] i_second_low_corner,
    input  wire logic [3*COMPONENT_WIDTH-1:0] i_second_high_corner,
    input  wire logic [3*COMPONENT_WIDTH-1:0] i_test_axis,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic                              o_overlapping,
    output logic [DEPTH_BITS-1:0]             o_depth_amount,
    output logic                              o_axis_degenerate
);

    `include "box_axis_overlap_depth_core_macros.svh"

    localparam int W = COMPONENT_WIDTH;

    logic             en;
    logic             p_valid;
    logic [2*W+3:0]   p_mag;
    logic             p_neg;
    logic [2*W-1:0]   p_q;
    logic             p_degen;
    logic             s_valid;
    logic [4*W+7:0]   s_sq;
    logic             s_neg;
    logic [2*W-1:0]   s_q;
    logic             s_degen;
    logic             r_valid;
    logic [DEPTH_BITS-1:0] r_depth;
    logic             r_neg;
    logic             r_degen;

    assign en      = !(r_valid && i_stall);
    assign o_stall = r_valid && i_stall;

    bao_proj #(.W(W)) u_proj (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_en                 (en),
        .i_valid              (i_valid),
        .i_first_low_corner   (i_first_low_corner),
        .i_first_high_corner  (i_first_high_corner),
        .i_second_low_corner  (i_second_low_corner),
        .i_second_high_corner (i_second_high_corner),
        .i_test_axis          (i_test_axis),
        .o_valid              (p_valid),
        .o_mag                (p_mag),
        .o_neg                (p_neg),
        .o_q                  (p_q),
        .o_degen              (p_degen)
    );

    bao_square #(.W(W)) u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (p_valid),
        .i_mag   (p_mag),
        .i_neg   (p_neg),
        .i_q     (p_q),
        .i_degen (p_degen),
        .o_valid (s_valid),
        .o_sq    (s_sq),
        .o_neg   (s_neg),
        .o_q     (s_q),
        .o_degen (s_degen)
    );

    bao_root #(.W(W)) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_valid),
        .i_sq    (s_sq),
        .i_neg   (s_neg),
        .i_q     (s_q),
        .i_degen (s_degen),
        .o_valid (r_valid),
        .o_depth (r_depth),
        .o_neg   (r_neg),
        .o_degen (r_degen)
    );

    assign o_valid           = r_valid;
    assign o_overlapping     = r_neg && !r_degen;
    assign o_depth_amount    = r_degen ? '0 : r_depth;
    assign o_axis_degenerate = r_degen;

    `BAO_ASSERT_IMPL(a_degen_clear, i_clk, i_rst_n,
        o_valid && o_axis_degenerate, !o_overlapping && (o_depth_amount == '0))
    `BAO_ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, o_stall, o_valid)
    `BAO_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_stall, o_valid)

endmodule

`default_nettype wire

FILE: sim/tb_box_axis_overlap_depth_core.sv
`timescale 1ns / 1ps

module tb_box_axis_overlap_depth_core;
    import bao_pkg::*;

    localparam int CW = COMPONENT_WIDTH_DEF;
    localparam int VW = 3 * CW;
    localparam int NUM_RANDOM = 1850;
    localparam int CALM_TAIL = 150;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LATENCY = 23;

    typedef struct packed {
        logic [VW-1:0] low1;
        logic [VW-1:0] high1;
        logic [VW-1:0] low2;
        logic [VW-1:0] high2;
        logic [VW-1:0] axis;
    } box_pair_t;

    typedef struct packed {
        logic                  overlapping;
        logic [DEPTH_BITS-1:0] depth;
        logic                  degenerate;
    } depth_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [VW-1:0] i_first_low_corner = '0;
    logic [VW-1:0] i_first_high_corner = '0;
    logic [VW-1:0] i_second_low_corner = '0;
    logic [VW-1:0] i_second_high_corner = '0;
    logic [VW-1:0] i_test_axis = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_overlapping;
    logic [DEPTH_BITS-1:0] o_depth_amount;
    logic o_axis_degenerate;

    box_pair_t pending_pairs[$];
    depth_result_t expected_depths[$];
    int errors = 0;
    int idle_cycles = 0;
    bit stimulus_done = 1'b0;
    bit calm = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;

    always #6 i_clk = ~i_clk;

    box_axis_overlap_depth_core dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_first_low_corner(i_first_low_corner),
        .i_first_high_corner(i_first_high_corner),
        .i_second_low_corner(i_second_low_corner),
        .i_second_high_corner(i_second_high_corner),
        .i_test_axis(i_test_axis),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_overlapping(o_overlapping),
        .o_depth_amount(o_depth_amount),
        .o_axis_degenerate(o_axis_degenerate)
    );

    function automatic longint component(input logic [VW-1:0] v, input int idx);
        logic signed [CW-1:0] c;
        c = v[idx*CW +: CW];
        return longint'(c);
    endfunction

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic depth_result_t project_overlap(input box_pair_t p);
        depth_result_t r;
        longint centre_dot, radius_sum, gap, dc, a;
        logic [127:0] gap_sq, trial_sq, axis_sq;
        logic [DEPTH_BITS-1:0] n, t;
        centre_dot = 0;
        radius_sum = 0;
        axis_sq = '0;
        for (int i = 0; i < 3; i++) begin
            a = component(p.axis, i);
            dc = (component(p.low1, i) + component(p.high1, i))
               - (component(p.low2, i) + component(p.high2, i));
            centre_dot += dc * a;
            radius_sum += magnitude((component(p.high1, i) - component(p.low1, i)) * a)
                        + magnitude((component(p.high2, i) - component(p.low2, i)) * a);
            axis_sq += 128'(a * a);
        end
        r = '0;
        if (axis_sq == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        gap = magnitude(centre_dot) - radius_sum;
        gap_sq = 128'(magnitude(gap)) * 128'(magnitude(gap));
        n = '0;
        for (int b = DEPTH_BITS - 1; b >= 0; b--) begin
            t = n | (DEPTH_BITS'(1) << b);
            trial_sq = 128'(4) * 128'(t) * 128'(t) * axis_sq;
            if (trial_sq <= gap_sq) begin
                n = t;
            end
        end
        r.overlapping = gap < 0;
        r.depth = n;
        return r;
    endfunction

    function automatic logic [CW-1:0] rand_component(input int kind);
        case (kind)
            0: return CW'($urandom);
            1: return CW'($urandom_range(0, 8)) - CW'(4);
            2: return {1'b0, {(CW-1){1'b1}}};
            3: return {1'b1, {(CW-1){1'b0}}};
            default: return CW'($urandom_range(0, 1024)) - CW'(512);
        endcase
    endfunction

    function automatic logic [VW-1:0] rand_vector(input int kind);
        logic [VW-1:0] v;
        for (int i = 0; i < 3; i++) begin
            v[i*CW +: CW] = rand_component((kind < 0) ? $urandom_range(0, 5) : kind);
        end
        return v;
    endfunction

    function automatic logic [VW-1:0] splat(input logic [CW-1:0] c);
        return {c, c, c};
    endfunction

    task automatic add_pair(input logic [VW-1:0] l1, input logic [VW-1:0] h1,
                            input logic [VW-1:0] l2, input logic [VW-1:0] h2,
                            input logic [VW-1:0] ax);
        box_pair_t p;
        p.low1 = l1;
        p.high1 = h1;
        p.low2 = l2;
        p.high2 = h2;
        p.axis = ax;
        pending_pairs.push_back(p);
    endtask

    initial begin
        logic [CW-1:0] maxc, minc, one;
        logic [VW-1:0] ax, c;
        maxc = {1'b0, {(CW-1){1'b1}}};
        minc = {1'b1, {(CW-1){1'b0}}};
        one = CW'(256);
        add_pair('0, '0, '0, '0, '0);
        add_pair(splat(one), splat(-one), '0, splat(one), '0);
        add_pair('0, splat(one), splat(one), splat(one * 2), {32'd0, one});
        add_pair('0, splat(one), splat(one * 2), splat(one * 3), {32'd0, one});
        add_pair('0, splat(one * 2), splat(one), splat(one * 3), {32'd0, one});
        add_pair(splat(one), '0, splat(one * 2), splat(one * 3), splat(one));
        add_pair(splat(minc), splat(maxc), splat(minc), splat(maxc), splat(maxc));
        add_pair(splat(minc), splat(minc), splat(maxc), splat(maxc), splat(minc));
        add_pair(splat(minc), splat(minc), splat(maxc), splat(maxc), {32'd0, CW'(1)});
        add_pair(splat(maxc), splat(minc), splat(maxc), splat(minc), splat(maxc));
        add_pair('1, '1, '1, '1, '1);
        add_pair('0, splat(maxc), splat(minc), '0, splat(CW'(1)));
        add_pair(splat(minc), splat(maxc), '0, '0, {minc, 16'd0, maxc});
        add_pair('0, splat(one), splat(one * 4), splat(one * 5), {CW'(3), CW'(-4), CW'(0)});
        for (int k = 0; k < NUM_RANDOM; k++) begin
            if ($urandom_range(0, 9) < 7) begin
                c = rand_vector(4);
                ax = rand_vector(($urandom_range(0, 3) == 0) ? 1 : -1);
                add_pair(c, c + rand_vector(1), c + rand_vector(4), c + rand_vector(4), ax);
            end else begin
                add_pair(rand_vector(-1), rand_vector(-1), rand_vector(-1), rand_vector(-1),
                         ($urandom_range(0, 19) == 0) ? '0 : rand_vector(-1));
            end
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(posedge i_clk) begin
        box_pair_t p;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_depths.push_back(project_overlap({i_first_low_corner,
                    i_first_high_corner, i_second_low_corner, i_second_high_corner,
                    i_test_axis}));
            end
            if (!i_valid || !o_stall) begin
                calm = pending_pairs.size() < CALM_TAIL;
                if (send_gap > 0 && !calm) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_pairs.size() == 0) begin
                    i_valid <= 1'b0;
                    stimulus_done <= 1'b1;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(0, 11);
                    i_valid <= 1'b0;
                end else begin
                    p = pending_pairs.pop_front();
                    i_valid <= 1'b1;
                    i_first_low_corner <= p.low1;
                    i_first_high_corner <= p.high1;
                    i_second_low_corner <= p.low2;
                    i_second_high_corner <= p.high2;
                    i_test_axis <= p.axis;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        depth_result_t want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_depths.size() == 0) begin
                    $display("%0t: unexpected result depth %0d", $time, o_depth_amount);
                    errors++;
                end else begin
                    want = expected_depths.pop_front();
                    if (o_overlapping !== want.overlapping) begin
                        $display("%0t: overlapping expected %0b actual %0b",
                                 $time, want.overlapping, o_overlapping);
                        errors++;
                    end
                    if (o_depth_amount !== want.depth) begin
                        $display("%0t: depth_amount expected %0d actual %0d",
                                 $time, want.depth, o_depth_amount);
                        errors++;
                    end
                    if (o_axis_degenerate !== want.degenerate) begin
                        $display("%0t: axis_degenerate expected %0b actual %0b",
                                 $time, want.degenerate, o_axis_degenerate);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0 && !calm) begin
                recv_gap <= recv_gap - 1;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(0, 11);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_box_axis_overlap_depth_core: FAIL");
            $finish;
        end
    end

    initial begin
        wait (stimulus_done && expected_depths.size() == 0);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (errors == 0 && expected_depths.size() == 0) begin
            $display("tb_box_axis_overlap_depth_core: PASS");
        end else begin
            $display("tb_box_axis_overlap_depth_core: FAIL");
        end
        $finish;
    end

endmodule
